// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl of the congestion window controller
// no dependencies; bodies vanish when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- src/tcprcc_pkg.sv -----
// types and constants of the congestion window controller
// no dependencies; used by tcprcc_div and tcp_reno_congestion_control_top
package tcprcc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SEG_W     = 16;
  localparam int unsigned DUP_W     = 8;
  localparam int unsigned RWIN_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned DIV_CNT_W = $clog2(DATA_W + 1);

  // register reset values
  localparam logic [SEG_W-1:0]  SEG_SIZE_RST    = 16'd1024;
  localparam logic [DATA_W-1:0] INIT_THRESH_RST = 32'd65536;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THRESH = 1'd1;

  // event kinds on the input channel
  localparam logic FUNC_ACK     = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  // duplicate ack handling
  localparam logic [DUP_W-1:0] DUP_TRIGGER = 8'd2;
  localparam logic [DUP_W-1:0] DUP_MAX     = 8'd255;

  typedef enum logic [1:0] {
    PH_SS = 2'd0,
    PH_CA = 2'd1,
    PH_FR = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    EV_NEW     = 2'd0,
    EV_TIMEOUT = 2'd1,
    EV_DUP     = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DIV  = 2'd2,
    ST_PUSH = 2'd3
  } state_e;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/tcprcc_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
// depends on tcprcc_pkg
module tcprcc_div
  import tcprcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output div_stat_t         stat_o,
  output logic [DATA_W-1:0] quot_o
);

  logic [DATA_W-1:0]    quot_q, quot_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic                 busy;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W+1:0]    diff;

  assign busy   = (cnt_q != '0);
  assign rem_sh = {rem_q, quot_q[DATA_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = DIV_CNT_W'(DATA_W);
    end else if (busy) begin
      // zero divisor always subtracts, giving an all-ones quotient
      if (!diff[DATA_W+1]) begin
        rem_d  = diff[DATA_W-1:0];
        quot_d = {quot_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[DATA_W-1:0];
        quot_d = {quot_q[DATA_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign stat_o.busy = busy;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

// ----- src/tcp_reno_congestion_control_top.sv -----
// top level of the sender-side reno congestion window controller
// depends on tcprcc_pkg, tcprcc_div and assert_macros.svh
//
// input channel (in_valid_i / in_stall_o) carries one event per transfer:
// a receive timeout or a received segment with its ack fields. output
// channel (out_valid_o / out_stall_i) returns exactly one result per event:
// window, threshold, phase, highest ack, duplicate count, peer window and
// the finished and error flags of that event.
// one event at a time: in_stall_o is high from the transfer until the
// result has been loaded into the output register.
// a result passes through the decode step and then the push step before it
// reaches out_valid_o. a new ack in congestion avoidance also runs the
// restoring divider for seg*seg/window between those steps, one quotient
// bit a cycle; no new event is taken until the result is loaded.
// a result waiting in the output register does not block a new transfer;
// only the next result waits for it, in the push step.
// reset: window = 1024, threshold = 65536, slow start, all ack tracking
// cleared, segment size register back to 1024. the threshold register
// only matters at reset, so writes to it have no later effect.
// configuration is written through cfg_we_i; write it only while the block is idle (the block does not enforce this).
`include "assert_macros.svh"

module tcp_reno_congestion_control_top
  import tcprcc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [DATA_W-1:0]    ack_number_i,
  input  logic [DATA_W-1:0]    expected_seq_i,
  input  logic                 ack_flag_i,
  input  logic                 final_flag_i,
  input  logic [RWIN_W-1:0]    receive_window_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DATA_W-1:0]    window_o,
  output logic [DATA_W-1:0]    threshold_o,
  output logic [1:0]           phase_o,
  output logic [DATA_W-1:0]    highest_ack_o,
  output logic [DUP_W-1:0]     dup_count_o,
  output logic                 finished_o,
  output logic [RWIN_W-1:0]    peer_window_o,
  output logic                 error_o
);

  // saturating add at the window width
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? '1 : s[DATA_W-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [SEG_W-1:0]  seg_size_q;

  // congestion state
  logic [DATA_W-1:0] cwnd_q, cwnd_d;
  logic [DATA_W-1:0] ssthresh_q, ssthresh_d;
  phase_e            phase_q, phase_d;
  logic [DATA_W-1:0] highest_ack_q, highest_ack_d;
  logic [DATA_W-1:0] last_ack_q, last_ack_d;
  logic [DUP_W-1:0]  dup_count_q, dup_count_d;
  logic [RWIN_W-1:0] peer_window_q, peer_window_d;
  logic              fin_res_q, fin_res_d;
  logic              err_res_q, err_res_d;

  // captured input item
  logic              func_q;
  logic [DATA_W-1:0] ack_q;
  logic [DATA_W-1:0] exp_q;
  logic              ackf_q;
  logic              fin_q;
  logic [RWIN_W-1:0] rwin_q;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_window_q;
  logic [DATA_W-1:0] out_thresh_q;
  logic [1:0]        out_phase_q;
  logic [DATA_W-1:0] out_highest_q;
  logic [DUP_W-1:0]  out_dup_q;
  logic              out_fin_q;
  logic [RWIN_W-1:0] out_peer_q;
  logic              out_err_q;

  logic              in_accept;
  logic              out_load;
  logic              div_start;
  div_stat_t         div_stat;
  logic [DATA_W-1:0] div_quot;
  logic [DATA_W-1:0] seg_sq;
  logic [DATA_W-1:0] seg_ext;
  logic [DATA_W-1:0] seg_x3;
  logic [DATA_W-1:0] half_cwnd;

  // event decode scratch
  logic              cc_fire;
  event_e            cc_ev;
  logic              cc_cut;
  logic [DUP_W-1:0]  dup_next;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign seg_ext   = DATA_W'(seg_size_q);
  assign seg_x3    = DATA_W'({seg_size_q, 1'b0}) + seg_ext;
  assign half_cwnd = cwnd_q >> 1;
  // 16x16 product, registered inside the divider on start
  assign seg_sq    = seg_ext * seg_ext;

  tcprcc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (seg_sq),
    .divisor_i  (cwnd_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  // sequencer: next state and state updates
  always_comb begin
    state_d       = state_q;
    cwnd_d        = cwnd_q;
    ssthresh_d    = ssthresh_q;
    phase_d       = phase_q;
    highest_ack_d = highest_ack_q;
    last_ack_d    = last_ack_q;
    dup_count_d   = dup_count_q;
    peer_window_d = peer_window_q;
    fin_res_d     = fin_res_q;
    err_res_d     = err_res_q;
    div_start     = 1'b0;
    out_load      = 1'b0;
    cc_fire       = 1'b0;
    cc_ev         = EV_NEW;
    cc_cut        = 1'b0;
    dup_next      = dup_count_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        fin_res_d = 1'b0;
        err_res_d = 1'b0;
        state_d   = ST_PUSH;

        // classify the event
        if (func_q == FUNC_TIMEOUT) begin
          cc_fire = 1'b1;
          cc_ev   = EV_TIMEOUT;
        end else if (ack_q == exp_q) begin
          peer_window_d = rwin_q;
          if (!ackf_q) begin
            err_res_d = 1'b1;
          end else begin
            highest_ack_d = ack_q;
            if (fin_q) begin
              fin_res_d = 1'b1;
            end else begin
              cc_fire = 1'b1;
              cc_ev   = EV_NEW;
            end
          end
        end else begin
          peer_window_d = rwin_q;
          if (ack_q == last_ack_q) begin
            if (dup_count_q != DUP_MAX) begin
              dup_next = dup_count_q + 1'b1;
            end
            dup_count_d = dup_next;
            if (dup_next >= DUP_TRIGGER) begin
              cc_fire = 1'b1;
              cc_ev   = EV_DUP;
            end
          end else begin
            last_ack_d  = ack_q;
            dup_count_d = '0;
          end
          // duplicate that reached the trigger skips the flag check
          if (!cc_fire) begin
            if (!ackf_q) begin
              err_res_d = 1'b1;
            end else if (ack_q > highest_ack_q) begin
              highest_ack_d = ack_q;
            end
          end
        end

        // congestion state machine
        if (cc_fire) begin
          case (phase_q)
            PH_FR: begin
              if (cc_ev == EV_DUP) begin
                cwnd_d = sat_add(cwnd_q, seg_ext);
              end else begin
                cwnd_d      = seg_ext;
                dup_count_d = '0;
                phase_d     = PH_SS;
              end
            end
            PH_CA: begin
              if (cc_ev == EV_NEW) begin
                div_start   = 1'b1;
                dup_count_d = '0;
                state_d     = ST_DIV;
              end else begin
                cc_cut = 1'b1;
              end
            end
            default: begin
              // slow start: reaching the threshold only switches phase
              if (cwnd_q >= ssthresh_q) begin
                phase_d = PH_CA;
              end else if (cc_ev == EV_NEW) begin
                cwnd_d      = sat_add(cwnd_q, seg_ext);
                dup_count_d = '0;
              end else begin
                cc_cut = 1'b1;
              end
            end
          endcase

          // timeout or second duplicate: halve into the threshold
          if (cc_cut) begin
            ssthresh_d = half_cwnd;
            if (cc_ev == EV_TIMEOUT) begin
              cwnd_d      = seg_ext;
              dup_count_d = '0;
              phase_d     = PH_SS;
            end else begin
              cwnd_d  = sat_add(half_cwnd, seg_x3);
              phase_d = PH_FR;
            end
          end
        end
      end

      ST_DIV: begin
        if (div_stat.done) begin
          cwnd_d  = sat_add(cwnd_q, div_quot);
          state_d = ST_PUSH;
        end
      end

      ST_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      seg_size_q    <= SEG_SIZE_RST;
      cwnd_q        <= DATA_W'(SEG_SIZE_RST);
      ssthresh_q    <= INIT_THRESH_RST;
      phase_q       <= PH_SS;
      highest_ack_q <= '0;
      last_ack_q    <= '0;
      dup_count_q   <= '0;
      peer_window_q <= '0;
      fin_res_q     <= 1'b0;
      err_res_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cwnd_q        <= cwnd_d;
      ssthresh_q    <= ssthresh_d;
      phase_q       <= phase_d;
      highest_ack_q <= highest_ack_d;
      last_ack_q    <= last_ack_d;
      dup_count_q   <= dup_count_d;
      peer_window_q <= peer_window_d;
      fin_res_q     <= fin_res_d;
      err_res_q     <= err_res_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SEG_SIZE:    seg_size_q <= cfg_data_i[SEG_W-1:0];
          // threshold only seeds reset state, later writes are dropped
          CFG_INIT_THRESH: ;
          default:         ;
        endcase
      end
    end
  end

  // input capture on transfer
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= func_i;
      ack_q  <= ack_number_i;
      exp_q  <= expected_seq_i;
      ackf_q <= ack_flag_i;
      fin_q  <= final_flag_i;
      rwin_q <= receive_window_i;
    end
  end

  // output register load
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_window_q  <= cwnd_q;
      out_thresh_q  <= ssthresh_q;
      out_phase_q   <= phase_q;
      out_highest_q <= highest_ack_q;
      out_dup_q     <= dup_count_q;
      out_fin_q     <= fin_res_q;
      out_peer_q    <= peer_window_q;
      out_err_q     <= err_res_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign window_o      = out_window_q;
  assign threshold_o   = out_thresh_q;
  assign phase_o       = out_phase_q;
  assign highest_ack_o = out_highest_q;
  assign dup_count_o   = out_dup_q;
  assign finished_o    = out_fin_q;
  assign peer_window_o = out_peer_q;
  assign error_o       = out_err_q;

  // a new result only appears after the push step
  `ASSERT_CLK(a_out_after_push, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_PUSH), "result without push step")
  // the divider runs only while the sequencer waits for it
  `ASSERT_CLK(a_div_owned, clk_i, rst_ni, div_stat.busy |-> (state_q == ST_DIV), "divider busy outside divide step")
  // the divide step never waits on an idle divider
  `ASSERT_NEVER(a_div_lost, clk_i, rst_ni, (state_q == ST_DIV) && !div_stat.busy && !div_stat.done, "divide step with idle divider")
  // an input transfer always leads to the decode step
  `ASSERT_CLK(a_accept_exec, clk_i, rst_ni, in_accept |=> (state_q == ST_EXEC), "transfer not decoded")

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for tcp_reno_congestion_control_top
// drives ack and timeout events, predicts every result in-line and compares
// depends on tcprcc_pkg and the rtl of the congestion window controller only
`timescale 1ns / 100ps

module tb_top
  import tcprcc_pkg::*;
();

  localparam int          CLK_HALF     = 6;
  localparam int          STUCK_LIMIT  = 2000;   // cycles without any transfer
  localparam int          LONG_HOLD    = 80;     // one long receiver hold-off
  localparam int          LONG_HOLD_AT = 120;    // results seen before it starts
  localparam int          SAT_DUPS     = 300;    // dup acks that clip the duplicate count
  localparam int          TAIL_CYCLES  = 40;
  localparam int          MAX_REPORTS  = 100;
  localparam logic [63:0] FR_SEGS      = 64'd3;  // segments added on entering fast retransmit

  // one received segment or timeout
  typedef struct {
    logic               func;
    logic [DATA_W-1:0]  ack;
    logic [DATA_W-1:0]  exp_seq;
    logic               ack_flag;
    logic               fin;
    logic [RWIN_W-1:0]  rwin;
  } seg_event_t;

  // controller state reported after one event
  typedef struct {
    logic [DATA_W-1:0]  window;
    logic [DATA_W-1:0]  threshold;
    logic [1:0]         phase;
    logic [DATA_W-1:0]  highest;
    logic [DUP_W-1:0]   dup;
    logic               finished;
    logic [RWIN_W-1:0]  peer;
    logic               error;
  } reno_result_t;

  // clock, reset and dut ports
  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]  cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic               ev_func     = 1'b0;
  logic [DATA_W-1:0]  ev_ack      = '0;
  logic [DATA_W-1:0]  ev_exp_seq  = '0;
  logic               ev_ack_flag = 1'b0;
  logic               ev_final    = 1'b0;
  logic [RWIN_W-1:0]  ev_rwin     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [DATA_W-1:0]  res_window;
  logic [DATA_W-1:0]  res_threshold;
  logic [1:0]         res_phase;
  logic [DATA_W-1:0]  res_highest;
  logic [DUP_W-1:0]   res_dup;
  logic               res_finished;
  logic [RWIN_W-1:0]  res_peer;
  logic               res_error;

  // pending segments for the driver and results still owed by the dut
  seg_event_t   seg_event_q[$];
  reno_result_t reno_result_q[$];

  // predicted controller state and its register copies
  logic [DATA_W-1:0]  cc_cwnd;
  logic [DATA_W-1:0]  cc_ssthresh;
  phase_e             cc_phase;
  logic [DATA_W-1:0]  cc_highest;
  logic [DATA_W-1:0]  cc_last_ack;
  logic [DUP_W-1:0]   cc_dup;
  logic [RWIN_W-1:0]  cc_peer;
  logic [SEG_W-1:0]   seg_cfg;
  logic [DATA_W-1:0]  init_thresh_cfg;

  // driver, receiver and run bookkeeping
  seg_event_t cur_event;
  int   gap_left     = 0;
  int   stall_left   = 0;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;
  logic quiet        = 1'b0;   // no idling on either side
  int   results_seen = 0;
  int   stuck_cycles = 0;
  int   mismatches   = 0;
  int   n_events     = 0;
  int   n_timeouts   = 0;
  int   n_new_acks   = 0;
  int   n_dup_acts   = 0;
  int   n_flag_errs  = 0;
  int   n_finished   = 0;
  int   n_saturated  = 0;

  tcp_reno_congestion_control_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (ev_func),
    .ack_number_i     (ev_ack),
    .expected_seq_i   (ev_exp_seq),
    .ack_flag_i       (ev_ack_flag),
    .final_flag_i     (ev_final),
    .receive_window_i (ev_rwin),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .window_o         (res_window),
    .threshold_o      (res_threshold),
    .phase_o          (res_phase),
    .highest_ack_o    (res_highest),
    .dup_count_o      (res_dup),
    .finished_o       (res_finished),
    .peer_window_o    (res_peer),
    .error_o          (res_error)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // window prediction
  // ---------------------------------------------------------------------------

  // every window sum clips at the 32 bit maximum
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [63:0] b);
    logic [63:0] s;
    s = {32'd0, a} + b;
    return (s > 64'h0000_0000_FFFF_FFFF) ? '1 : s[DATA_W-1:0];
  endfunction

  // congestion state machine for one new ack, timeout or duplicate ack action
  task automatic reno_cc_event(input event_e ev);
    logic [63:0] seg;
    logic [63:0] quo;
    seg = {48'd0, seg_cfg};
    if (cc_phase == PH_FR) begin
      if (ev == EV_DUP) begin
        cc_cwnd = sat_add(cc_cwnd, seg);
      end else begin
        cc_cwnd  = seg[DATA_W-1:0];
        cc_dup   = '0;
        cc_phase = PH_SS;
      end
      return;
    end
    if (cc_phase == PH_CA) begin
      if (ev == EV_NEW) begin
        // integer form of cwnd += seg*seg/cwnd, zero window gives all ones
        quo = (cc_cwnd == '0) ? 64'hFFFF_FFFF : (seg * seg) / {32'd0, cc_cwnd};
        cc_cwnd = sat_add(cc_cwnd, quo);
        cc_dup  = '0;
        return;
      end
    end else begin
      // slow start quirk: crossing the threshold swallows the event
      if (cc_cwnd >= cc_ssthresh) begin
        cc_phase = PH_CA;
        return;
      end
      if (ev == EV_NEW) begin
        cc_cwnd = sat_add(cc_cwnd, seg);
        cc_dup  = '0;
        return;
      end
    end
    cc_ssthresh = cc_cwnd >> 1;
    if (ev == EV_TIMEOUT) begin
      cc_cwnd  = seg[DATA_W-1:0];
      cc_dup   = '0;
      cc_phase = PH_SS;
    end else begin
      cc_cwnd  = sat_add(cc_ssthresh, FR_SEGS * seg);
      cc_phase = PH_FR;
    end
  endtask

  // full handling of one accepted segment, returns the result it must produce
  task automatic reno_predict(input seg_event_t ev, output reno_result_t res);
    logic handled;
    handled      = 1'b0;
    res.finished = 1'b0;
    res.error    = 1'b0;
    if (ev.func == FUNC_TIMEOUT) begin
      n_timeouts++;
      reno_cc_event(EV_TIMEOUT);
    end else if (ev.ack == ev.exp_seq) begin
      cc_peer = ev.rwin;
      if (!ev.ack_flag) begin
        res.error = 1'b1;
      end else begin
        cc_highest = ev.ack;
        if (ev.fin) begin
          res.finished = 1'b1;
        end else begin
          n_new_acks++;
          reno_cc_event(EV_NEW);
        end
      end
    end else begin
      cc_peer = ev.rwin;
      if (ev.ack == cc_last_ack) begin
        if (cc_dup < DUP_MAX) cc_dup = cc_dup + 1'b1;
        if (cc_dup >= DUP_TRIGGER) begin
          n_dup_acts++;
          reno_cc_event(EV_DUP);
          handled = 1'b1;
        end
      end else begin
        cc_last_ack = ev.ack;
        cc_dup      = '0;
      end
      // the flag check and highest ack update are skipped on a dup action
      if (!handled) begin
        if (!ev.ack_flag) res.error = 1'b1;
        else if (ev.ack > cc_highest) cc_highest = ev.ack;
      end
    end
    res.window    = cc_cwnd;
    res.threshold = cc_ssthresh;
    res.phase     = cc_phase;
    res.highest   = cc_highest;
    res.dup       = cc_dup;
    res.peer      = cc_peer;
    if (res.error) n_flag_errs++;
    if (res.finished) n_finished++;
    if (cc_cwnd == '1) n_saturated++;
  endtask

  // ---------------------------------------------------------------------------
  // input driver: one segment at a time from the pending queue
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin : drive_segment
      seg_event_t   nxt;
      reno_result_t want;
      logic         free;
      free = !in_valid || !in_stall;
      // transfer at this edge: predict its result now
      if (in_valid && !in_stall) begin
        reno_predict(cur_event, want);
        reno_result_q.push_back(want);
        n_events++;
      end
      if (free) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (seg_event_q.size() != 0) begin
          nxt = seg_event_q.pop_front();
          cur_event   <= nxt;
          ev_func     <= nxt.func;
          ev_ack      <= nxt.ack;
          ev_exp_seq  <= nxt.exp_seq;
          ev_ack_flag <= nxt.ack_flag;
          ev_final    <= nxt.fin;
          ev_rwin     <= nxt.rwin;
          in_valid    <= 1'b1;
          // idle burst after this segment has gone
          if (!quiet && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: short random stall bursts and one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= LONG_HOLD_AT) begin
      // the sender keeps offering, so the block fills and stalls its input
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // result checking against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string fname, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    reno_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (reno_result_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, actual window %0h",
                 $time, res_window);
      end else begin
        want = reno_result_q.pop_front();
        check_field("window",      want.window,    res_window);
        check_field("threshold",   want.threshold, res_threshold);
        check_field("phase",       want.phase,     res_phase);
        check_field("highest_ack", want.highest,   res_highest);
        check_field("dup_count",   want.dup,       res_dup);
        check_field("finished",    want.finished,  res_finished);
        check_field("peer_window", want.peer,      res_peer);
        check_field("error",       want.error,     res_error);
      end
    end
  end

  // watchdog: cycles in which neither channel moves a transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(negedge clk);
    $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
    $display("tcp_reno_congestion_control_top regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_event(input logic fn, input logic [DATA_W-1:0] a, e,
                            input logic af, ff, input logic [RWIN_W-1:0] rw);
    seg_event_t it;
    it.func     = fn;
    it.ack      = a;
    it.exp_seq  = e;
    it.ack_flag = af;
    it.fin      = ff;
    it.rwin     = rw;
    seg_event_q.push_back(it);
  endtask

  // wait until nothing is queued, offered or owed; the sender pauses here
  task automatic drain();
    @(negedge clk);
    while (seg_event_q.size() != 0 || in_valid || reno_result_q.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // register write while the block is idle, mirrored into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SEG_SIZE) seg_cfg = val[SEG_W-1:0];
    else init_thresh_cfg = val;
  endtask

  // mostly well-formed traffic: new acks, duplicate runs and timeouts,
  // with stray acks and fully random segments mixed in
  task automatic push_random(input int count);
    int   added;
    int   kind;
    int   run_len;
    logic [DATA_W-1:0] v;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 99);
      v    = $urandom;
      if (kind < 15) begin
        push_event(FUNC_TIMEOUT, v, $urandom, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        added++;
      end else if (kind < 45) begin
        push_event(FUNC_ACK, v, v, $urandom_range(0, 19) != 0, $urandom_range(0, 9) == 0,
                   16'($urandom_range(0, 65535)));
        added++;
      end else if (kind < 75) begin
        run_len = $urandom_range(2, 6);
        repeat (run_len)
          push_event(FUNC_ACK, v, v + $urandom_range(1, 1000), $urandom_range(0, 9) != 0,
                     1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        added += run_len;
      end else if (kind < 85) begin
        push_event(FUNC_ACK, v, v + 32'd1 + $urandom_range(0, 32'hFFFF_FFFD),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)));
        added++;
      end else begin
        push_event(1'($urandom_range(0, 1)), v, ($urandom_range(0, 3) == 0) ? v : $urandom,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)));
        added++;
      end
    end
  endtask

  task automatic random_phase(input logic [SEG_W-1:0] seg, input logic [DATA_W-1:0] thr,
                              input int count);
    drain();
    write_reg(CFG_SEG_SIZE, {16'd0, seg});
    write_reg(CFG_INIT_THRESH, thr);
    @(negedge clk);
    push_random(count);
  endtask

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int hop;
    logic [DATA_W-1:0] v;
    seg_cfg         = SEG_SIZE_RST;
    init_thresh_cfg = INIT_THRESH_RST;
    cc_cwnd         = {16'd0, SEG_SIZE_RST};
    cc_ssthresh     = INIT_THRESH_RST;
    cc_phase        = PH_SS;
    cc_highest      = '0;
    cc_last_ack     = '0;
    cc_dup          = '0;
    cc_peer         = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset settings, field extremes and every kind of event
    push_event(FUNC_ACK, 32'd0, 32'd0, 1'b1, 1'b0, 16'h0000);        // new ack from zero
    push_event(FUNC_ACK, '1, '1, 1'b1, 1'b0, 16'hFFFF);               // top ack number
    push_event(FUNC_ACK, 32'd100, 32'd100, 1'b0, 1'b1, 16'h1234);     // new ack, flag missing
    push_event(FUNC_ACK, 32'd200, 32'd200, 1'b1, 1'b1, 16'h0007);     // final segment
    push_event(FUNC_ACK, 32'd5, 32'd6, 1'b0, 1'b0, 16'h0001);         // stray ack, flag missing
    push_event(FUNC_ACK, 32'd5, 32'd7, 1'b1, 1'b0, 16'h0002);         // first repeat
    push_event(FUNC_ACK, 32'd5, 32'd8, 1'b1, 1'b0, 16'h0003);         // second repeat acts
    push_event(FUNC_ACK, 32'd5, 32'd9, 1'b0, 1'b1, 16'h0004);         // repeat in fast retransmit
    push_event(FUNC_ACK, 32'd300, 32'd300, 1'b1, 1'b0, 16'h0005);     // new ack leaves it
    push_event(FUNC_TIMEOUT, 32'd0, 32'd1, 1'b0, 1'b0, 16'h0000);
    push_event(FUNC_TIMEOUT, 32'd0, 32'd0, 1'b1, 1'b0, 16'h0000);
    push_event(FUNC_ACK, 32'd9, 32'd10, 1'b1, 1'b0, 16'h0100);
    push_event(FUNC_ACK, 32'd9, 32'd11, 1'b1, 1'b0, 16'h0200);
    push_event(FUNC_ACK, 32'd9, 32'd12, 1'b1, 1'b0, 16'h0300);
    push_event(FUNC_TIMEOUT, 32'd9, 32'd9, 1'b1, 1'b0, 16'h0000);
    push_event(FUNC_ACK, 32'd400, 32'd400, 1'b1, 1'b0, 16'h0400);     // threshold quirk
    push_event(FUNC_ACK, 32'd500, 32'd500, 1'b1, 1'b0, 16'h0500);     // avoidance divide
    push_event(FUNC_ACK, 32'd600, 32'd600, 1'b1, 1'b0, 16'h0600);
    push_event(FUNC_TIMEOUT, 32'd0, 32'd0, 1'b0, 1'b0, 16'h0000);     // timeout in avoidance
    push_event(FUNC_ACK, 32'd7, 32'd8, 1'b1, 1'b0, 16'h0700);         // below highest ack
    push_event(FUNC_ACK, 32'h8000_0000, 32'd1, 1'b1, 1'b0, 16'h8000);
    push_event(FUNC_ACK, 32'h8000_0000, 32'd2, 1'b1, 1'b0, 16'h8001);
    push_event(FUNC_ACK, 32'h8000_0000, 32'd3, 1'b1, 1'b0, 16'h8002);
    push_event(FUNC_TIMEOUT, '1, '1, 1'b1, 1'b1, 16'hFFFF);           // all other bits set

    // window of one in avoidance at segment size one
    drain();
    write_reg(CFG_SEG_SIZE, 32'd1);
    write_reg(CFG_INIT_THRESH, 32'd1);
    hop = 0;
    while (!(cc_phase == PH_CA && cc_cwnd == 32'd1) && hop < 8) begin
      @(negedge clk);
      push_event(FUNC_TIMEOUT, $urandom, $urandom, 1'b1, 1'b0,
                 16'($urandom_range(0, 65535)));
      drain();
      hop++;
    end
    // largest segment then divides by one, a duplicate run enters fast
    // retransmit near half range and long repeats clip the duplicate count
    write_reg(CFG_SEG_SIZE, {16'd0, 16'hFFFF});
    write_reg(CFG_INIT_THRESH, '1);
    @(negedge clk);
    v = $urandom;
    push_event(FUNC_ACK, v, v, 1'b1, 1'b0, 16'h2000);
    v = $urandom;
    repeat (SAT_DUPS)
      push_event(FUNC_ACK, v, v + 32'd1, 1'b1, 1'b0, 16'($urandom_range(0, 65535)));

    // random traffic under several settings, the last one without idling
    random_phase(16'd1, 32'h8000_0000, 100);
    random_phase(16'hFFFF, 32'd1, 100);
    random_phase(16'($urandom_range(2, 65534)), $urandom_range(1, 32'hFFFF_FFFF), 100);
    drain();
    quiet = 1'b1;
    random_phase(SEG_SIZE_RST, INIT_THRESH_RST, 100);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (reno_result_q.size() != 0) begin
      mismatches++;
      $display("%0t: results left over, expected %0d more, actual 0", $time,
               reno_result_q.size());
    end
    $display("covered %0d events: %0d timeouts, %0d new acks, %0d duplicate ack actions",
             n_events, n_timeouts, n_new_acks, n_dup_acts);
    $display("%0d flag errors, %0d finished flows, %0d saturated windows, %0d mismatches",
             n_flag_errs, n_finished, n_saturated, mismatches);
    if (mismatches == 0) begin
      $display("tcp_reno_congestion_control_top regression: pass");
    end else begin
      $display("tcp_reno_congestion_control_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/tcprcc_pkg.sv
src/tcprcc_div.sv
src/tcp_reno_congestion_control_top.sv
test/tb_top.sv
